// ===== src/vict_pkg.sv =====
package vict_pkg;

  // Default and fixed sizes of the controller.
  localparam int NUM_SOURCES_DEF = 8;
  localparam int VECTOR_BITS     = 32;
  localparam int TIMER_BITS      = 16;
  localparam int REPEAT_BITS     = 16;
  localparam int SRC_BITS        = 3;
  localparam int KIND_BITS       = 3;
  localparam int CFG_IDX_BITS    = 1;
  localparam int CFG_DATA_BITS   = 16;

  // Source that the timer raises on expiry.
  localparam int TIMER_SOURCE = 6;

  // Operation codes carried in the kind field.
  typedef enum logic [KIND_BITS-1:0] {
    K_TICK    = 3'd0,
    K_REQUEST = 3'd1,
    K_ENABLE  = 3'd2,
    K_DISABLE = 3'd3,
    K_CHECK   = 3'd4,
    K_ARM     = 3'd5
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ACTIVE = 1'b0,
    CFG_RELOAD = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [SRC_BITS-1:0]    source;
    logic [VECTOR_BITS-1:0] vector;
    logic [TIMER_BITS-1:0]  timer_load;
    logic [REPEAT_BITS-1:0] repeat_load;
  } in_item_t;

  typedef struct packed {
    logic                   found;
    logic [SRC_BITS-1:0]    source_out;
    logic [VECTOR_BITS-1:0] vector_out;
  } out_item_t;

  // Decision of the control logic for the item accepted in this cycle.
  typedef struct packed {
    logic                found;
    logic                wr;
    logic [SRC_BITS-1:0] source;
  } ack_t;

endpackage

// ===== src/vectored_interrupt_controller_timer.sv =====
// Fixed-priority vectored interrupt controller with a repeating countdown
// timer. Every input item (tick, request, enable, disable, check, arm) yields
// exactly one result item; only a check that finds an enabled pending source
// returns a nonzero result. The block takes one item per cycle while its
// input is not stalled; a result passes through the first stage, which holds
// the registered vector RAM read, then the output register. A stalled output
// holds one finished result plus one in flight before the input stalls. Masks
// and the timer live in flip-flops and are updated in the cycle of acceptance,
// so the next item always sees them. Vector entries need no clearing after
// reset, since only entries of enabled sources, written on enable, are read.
module vectored_interrupt_controller_timer #(
  parameter int NUM_SOURCES = vict_pkg::NUM_SOURCES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  vict_pkg::in_item_t                 in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output vict_pkg::out_item_t                out_item_o,
  input  logic                               cfg_we_i,
  input  logic [vict_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [vict_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);
  import vict_pkg::*;

  localparam int AW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

  logic                   in_acc, p1_adv;
  ack_t                   ack;
  logic [AW-1:0]          rd_idx;
  logic [VECTOR_BITS-1:0] rdata;
  logic                   p1_vld_q, p1_vld_d;
  logic                   p1_found_q;
  logic [SRC_BITS-1:0]    p1_src_q;
  logic                   out_vld_q, out_vld_d;
  out_item_t              out_q;

  // The first stage moves on whenever the output register is free or taken.
  assign p1_adv     = !out_vld_q || !out_stall_i;
  assign in_stall_o = p1_vld_q && !p1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  vict_ctrl #(
    .NUM_SOURCES(NUM_SOURCES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (in_acc),
    .item_i     (in_item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ack_o      (ack),
    .rd_idx_o   (rd_idx)
  );

  vict_ram #(
    .WIDTH(VECTOR_BITS),
    .DEPTH(NUM_SOURCES)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && ack.wr),
    .waddr_i (AW'(in_item_i.source)),
    .wdata_i (in_item_i.vector),
    .re_i    (in_acc && ack.found),
    .raddr_i (rd_idx),
    .rdata_o (rdata)
  );

  // Valid flags of the two stages.
  always_comb begin
    p1_vld_d  = p1_vld_q;
    out_vld_d = out_vld_q;
    if (p1_adv) begin
      out_vld_d = p1_vld_q;
      p1_vld_d  = 1'b0;
    end
    if (in_acc) begin
      p1_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      p1_vld_q  <= p1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload of the two stages; the vector joins from the RAM read port.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p1_found_q <= ack.found;
      p1_src_q   <= ack.source;
    end
    if (p1_adv && p1_vld_q) begin
      out_q.found      <= p1_found_q;
      out_q.source_out <= p1_src_q;
      out_q.vector_out <= p1_found_q ? rdata : '0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  // The input stalls only while a result waits in the first stage.
  a_stall_needs_p1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> p1_vld_q)
    else $error("input stalled with an empty first stage");

  // A held first-stage result is not dropped while the output is blocked.
  a_p1_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1_vld_q && out_vld_q && out_stall_i |=> p1_vld_q && out_vld_q)
    else $error("result lost under output stall");

  // A result that found nothing carries zero source and vector.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.found |->
      out_item_o.source_out == '0 && out_item_o.vector_out == '0)
    else $error("nonzero payload on a result that found nothing");

endmodule

// ===== src/vict_ram.sv =====
module vict_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single write port, single registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/vict_ctrl.sv =====
module vict_ctrl #(
  parameter int NUM_SOURCES = vict_pkg::NUM_SOURCES_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   acc_i,
  input  vict_pkg::in_item_t                     item_i,
  input  logic                                   cfg_we_i,
  input  logic [vict_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [vict_pkg::CFG_DATA_BITS-1:0]     cfg_data_i,
  output vict_pkg::ack_t                         ack_o,
  output logic [((NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1)-1:0] rd_idx_o
);
  import vict_pkg::*;

  localparam int AW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

  logic                   active_q;
  logic [TIMER_BITS-1:0]  reload_q;
  logic [NUM_SOURCES-1:0] enable_q, enable_d;
  logic [NUM_SOURCES-1:0] pending_q, pending_d;
  logic [TIMER_BITS-1:0]  count_q, count_d, count_dec;
  logic [REPEAT_BITS-1:0] repeat_q, repeat_d, repeat_dec;
  logic [NUM_SOURCES-1:0] src_bit, tmr_bit, live;
  logic                   src_ok, any_live;
  logic [AW-1:0]          win_idx;
  logic [SRC_BITS-1:0]    win_src;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b1;
      reload_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ACTIVE: active_q <= cfg_data_i[0];
        CFG_RELOAD: reload_q <= cfg_data_i[TIMER_BITS-1:0];
        default:    ;
      endcase
    end
  end

  // One-hot decode of the item's source and of the timer source.
  always_comb begin
    for (int i = 0; i < NUM_SOURCES; i++) begin
      src_bit[i] = (i == int'(item_i.source));
      tmr_bit[i] = (i == TIMER_SOURCE);
    end
  end

  assign src_ok = int'(item_i.source) < NUM_SOURCES;
  assign live   = enable_q & pending_q;

  // Fixed priority: the lowest-numbered live source wins.
  always_comb begin
    any_live = 1'b0;
    win_idx  = '0;
    win_src  = '0;
    for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
      if (live[i]) begin
        any_live = 1'b1;
        win_idx  = AW'(i);
        win_src  = SRC_BITS'(i);
      end
    end
  end

  assign count_dec  = count_q - 1'b1;
  assign repeat_dec = repeat_q - 1'b1;

  // Masks and timer, updated for the accepted item.
  always_comb begin
    enable_d     = enable_q;
    pending_d    = pending_q;
    count_d      = count_q;
    repeat_d     = repeat_q;
    ack_o.found  = 1'b0;
    ack_o.wr     = 1'b0;
    ack_o.source = '0;
    if (acc_i) begin
      unique case (kind_e'(item_i.kind))
        K_TICK: begin
          if (count_q != '0) begin
            count_d = count_dec;
            if (count_dec == '0) begin
              pending_d = pending_q | (tmr_bit & enable_q);
              if (repeat_q != '0) begin
                repeat_d = repeat_dec;
                count_d  = (repeat_dec == '0) ? '0 : reload_q;
              end else begin
                count_d = reload_q;
              end
            end
          end
        end
        K_REQUEST: pending_d = pending_q | (src_bit & enable_q);
        K_ENABLE: begin
          enable_d = enable_q | src_bit;
          ack_o.wr = src_ok;
        end
        K_DISABLE: enable_d = enable_q & ~src_bit;
        K_CHECK: begin
          if (active_q && any_live) begin
            ack_o.found = 1'b1;
            ack_o.source = win_src;
            pending_d[win_idx] = 1'b0;
          end
        end
        K_ARM: begin
          count_d  = item_i.timer_load;
          repeat_d = item_i.repeat_load;
        end
        default: ;
      endcase
    end
  end

  assign rd_idx_o = win_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= '0;
      pending_q <= '0;
      count_q   <= '0;
      repeat_q  <= '0;
    end else begin
      enable_q  <= enable_d;
      pending_q <= pending_d;
      count_q   <= count_d;
      repeat_q  <= repeat_d;
    end
  end

endmodule

// ===== sim/vectored_interrupt_controller_timer_tb.sv =====
`timescale 1ns / 100ps

module vectored_interrupt_controller_timer_tb;
  import vict_pkg::*;

  localparam int NUM_SRC = NUM_SOURCES_DEF;
  // Wait after nothing is outstanding, before a register write or the end.
  localparam int DRAIN = 8;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 155;

  // Kind codes that the block must ignore.
  localparam logic [KIND_BITS-1:0] KIND_SPARE_A = 3'd6;
  localparam logic [KIND_BITS-1:0] KIND_SPARE_B = 3'd7;

  localparam out_item_t NONE = '0;

  // One row of the directed script; pinned rows carry a hand-written result.
  typedef struct {
    in_item_t  item;
    bit        pinned;
    out_item_t res;
  } script_row_t;

  typedef struct {
    bit        pinned;
    out_item_t res;
  } pin_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  in_item_t                 in_item_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  out_item_t                out_item_o;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;

  // Controller state as the testbench sees it.
  logic                   ctl_active;
  logic [TIMER_BITS-1:0]  ctl_reload;
  logic [NUM_SRC-1:0]     enabled;
  logic [NUM_SRC-1:0]     pending;
  logic [VECTOR_BITS-1:0] vectors [NUM_SRC];
  logic [TIMER_BITS-1:0]  countdown;
  logic [REPEAT_BITS-1:0] repeats_left;

  pin_t        pin_q[$];
  out_item_t   awaited_q[$];
  script_row_t script_q[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;

  vectored_interrupt_controller_timer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one item to the state copy and returns the result it should give.
  function automatic out_item_t next_result(in_item_t it);
    out_item_t           res;
    logic [SRC_BITS-1:0] src;
    res = '0;
    src = it.source;
    case (it.kind)
      K_TICK: begin
        if (countdown != 0) begin
          countdown = countdown - 1'b1;
          if (countdown == 0) begin
            if (enabled[TIMER_SOURCE]) pending[TIMER_SOURCE] = 1'b1;
            // The last counted expiry leaves the timer stopped.
            if (repeats_left == 1) begin
              repeats_left = '0;
            end else begin
              if (repeats_left != 0) repeats_left = repeats_left - 1'b1;
              countdown = ctl_reload;
            end
          end
        end
      end
      K_REQUEST: begin
        if (enabled[src]) pending[src] = 1'b1;
      end
      K_ENABLE: begin
        enabled[src] = 1'b1;
        vectors[src] = it.vector;
      end
      K_DISABLE: begin
        enabled[src] = 1'b0;
      end
      K_CHECK: begin
        // Lowest-numbered enabled pending source wins.
        if (ctl_active) begin
          for (int i = 0; i < NUM_SRC; i++) begin
            if (!res.found && enabled[i] && pending[i]) begin
              pending[i]     = 1'b0;
              res.found      = 1'b1;
              res.source_out = i[SRC_BITS-1:0];
              res.vector_out = vectors[i];
            end
          end
        end
      end
      K_ARM: begin
        countdown    = it.timer_load;
        repeats_left = it.repeat_load;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic in_item_t op(logic [KIND_BITS-1:0] kind, int unsigned src,
                                  logic [VECTOR_BITS-1:0] vec,
                                  logic [TIMER_BITS-1:0] tload,
                                  logic [REPEAT_BITS-1:0] rload);
    in_item_t it;
    it.kind        = kind;
    it.source      = src[SRC_BITS-1:0];
    it.vector      = vec;
    it.timer_load  = tload;
    it.repeat_load = rload;
    return it;
  endfunction

  function automatic out_item_t hit(int unsigned src, logic [VECTOR_BITS-1:0] vec);
    out_item_t res;
    res.found      = 1'b1;
    res.source_out = src[SRC_BITS-1:0];
    res.vector_out = vec;
    return res;
  endfunction

  // Ends a burst now and then with a gap of random length.
  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Offers one item and holds it until the block takes it.
  task automatic offer(in_item_t it, bit pinned, out_item_t res);
    pin_q.push_back('{pinned: pinned, res: res});
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pace();
  endtask

  // Waits for the block to drain, then writes one register.
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_BITS-1:0] data);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pin_q.size() != 0 || awaited_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ACTIVE: ctl_active = data[0];
      CFG_RELOAD: ctl_reload = data;
      default: begin
      end
    endcase
  endtask

  // One setting of the registers followed by random items; mostly ticks,
  // requests and checks so that the timer expires and checks often hit.
  task automatic run_phase(logic active, logic [CFG_DATA_BITS-1:0] reload);
    in_item_t    it;
    int unsigned sent;
    int unsigned pick;
    write_reg(CFG_ACTIVE, {{(CFG_DATA_BITS-1){1'b0}}, active});
    write_reg(CFG_RELOAD, reload);
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      pick = $urandom_range(99);
      it.source      = SRC_BITS'($urandom_range(NUM_SRC - 1));
      it.vector      = $urandom();
      it.timer_load  = ($urandom_range(4) == 0) ? TIMER_BITS'($urandom_range(65535))
                                                : TIMER_BITS'($urandom_range(8));
      it.repeat_load = ($urandom_range(3) == 0) ? REPEAT_BITS'($urandom_range(65535))
                                                : REPEAT_BITS'($urandom_range(3));
      if (pick < 33) it.kind = K_TICK;
      else if (pick < 53) it.kind = K_REQUEST;
      else if (pick < 63) it.kind = K_ENABLE;
      else if (pick < 70) it.kind = K_DISABLE;
      else if (pick < 90) it.kind = K_CHECK;
      else if (pick < 97) it.kind = K_ARM;
      else it.kind = $urandom_range(1) ? KIND_SPARE_A : KIND_SPARE_B;
      offer(it, 1'b0, NONE);
      if (it.kind <= K_ARM) sent++;
    end
  endtask

  // Scoreboard: predicts on each accepted item and checks each accepted result.
  always @(posedge clk_i) begin : scoreboard
    pin_t      pin;
    out_item_t want;
    out_item_t predicted;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_q.size() == 0) begin
          $error("result item with nothing awaited");
          mismatches++;
        end else begin
          want = awaited_q.pop_front();
          if (out_item_o.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_item_o.found);
            mismatches++;
          end
          if (out_item_o.source_out !== want.source_out) begin
            $error("source_out: expected %0d, got %0d", want.source_out,
                   out_item_o.source_out);
            mismatches++;
          end
          if (out_item_o.vector_out !== want.vector_out) begin
            $error("vector_out: expected %h, got %h", want.vector_out,
                   out_item_o.vector_out);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        pin = pin_q.pop_front();
        predicted = next_result(in_item_i);
        awaited_q.push_back(pin.pinned ? pin.res : predicted);
      end
    end
  end

  // Output stall patterns, with long hold-offs that back the block up.
  initial begin : receiver
    int unsigned seg;
    int unsigned len;
    int unsigned period;
    seg = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      seg++;
      len = $urandom_range(20, 80);
      if (seg == 5 || seg == 60) begin
        out_stall_i <= 1'b1;
        repeat (200) @(posedge clk_i);
      end else begin
        case ($urandom_range(3))
          0: begin
            out_stall_i <= 1'b0;
            repeat (len) @(posedge clk_i);
          end
          1: begin
            for (int i = 0; i < len; i++) begin
              out_stall_i <= ($urandom_range(9) < 4);
              @(posedge clk_i);
            end
          end
          2: begin
            period = $urandom_range(2, 5);
            for (int i = 0; i < len; i++) begin
              out_stall_i <= (i % period == 0);
              @(posedge clk_i);
            end
          end
          default: begin
            out_stall_i <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clk_i);
            out_stall_i <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk_i);
          end
        endcase
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("vectored_interrupt_controller_timer_tb: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    ctl_active   = 1'b1;
    ctl_reload   = '0;
    enabled      = '0;
    pending      = '0;
    countdown    = '0;
    repeats_left = '0;
    for (int i = 0; i < NUM_SRC; i++) vectors[i] = '0;

    // Directed script at the reset settings (active, reload period zero).
    script_q.push_back('{op(K_CHECK, 0, 0, 0, 0), 1'b1, NONE});
    script_q.push_back('{op(K_ENABLE, 0, 32'hFFFF_FFFF, 0, 0), 1'b1, NONE});
    script_q.push_back('{op(K_ENABLE, 7, 32'h0, 0, 0), 1'b1, NONE});
    script_q.push_back('{op(K_REQUEST, 7, 0, 0, 0), 1'b1, NONE});
    // A request on a disabled source is dropped.
    script_q.push_back('{op(K_REQUEST, 3, 0, 0, 0), 1'b1, NONE});
    script_q.push_back('{op(K_CHECK, 0, 0, 0, 0), 1'b1, hit(7, 32'h0)});
    script_q.push_back('{op(K_REQUEST, 0, 0, 0, 0), 1'b1, NONE});
    script_q.push_back('{op(K_REQUEST, 7, 0, 0, 0), 1'b1, NONE});
    script_q.push_back('{op(K_CHECK, 0, 0, 0, 0), 1'b1, hit(0, 32'hFFFF_FFFF)});
    // Disabling masks the pending bit; enabling again shows it with a new vector.
    script_q.push_back('{op(K_DISABLE, 7, 0, 0, 0), 1'b1, NONE});
    script_q.push_back('{op(K_CHECK, 0, 0, 0, 0), 1'b1, NONE});
    script_q.push_back('{op(K_ENABLE, 7, 32'hA5A5_5A5A, 0, 0), 1'b1, NONE});
    script_q.push_back('{op(K_CHECK, 0, 0, 0, 0), 1'b1, hit(7, 32'hA5A5_5A5A)});
    // Timer with a single counted expiry, then a tick on the stopped timer.
    script_q.push_back('{op(K_ENABLE, 6, 32'h1234_5678, 0, 0), 1'b0, NONE});
    script_q.push_back('{op(K_ARM, 0, 0, 2, 1), 1'b0, NONE});
    script_q.push_back('{op(K_TICK, 0, 0, 0, 0), 1'b0, NONE});
    script_q.push_back('{op(K_TICK, 0, 0, 0, 0), 1'b0, NONE});
    script_q.push_back('{op(K_TICK, 0, 0, 0, 0), 1'b0, NONE});
    script_q.push_back('{op(K_CHECK, 0, 0, 0, 0), 1'b1, hit(6, 32'h1234_5678)});
    script_q.push_back('{op(K_CHECK, 0, 0, 0, 0), 1'b1, NONE});
    // Arming with a zero count leaves the timer stopped.
    script_q.push_back('{op(K_ARM, 0, 0, 0, 5), 1'b0, NONE});
    script_q.push_back('{op(K_TICK, 0, 0, 0, 0), 1'b0, NONE});
    script_q.push_back('{op(K_CHECK, 0, 0, 0, 0), 1'b1, NONE});
    // Unused kinds change nothing.
    script_q.push_back('{op(KIND_SPARE_A, 7, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF), 1'b1, NONE});
    script_q.push_back('{op(KIND_SPARE_B, 5, 32'h5555_AAAA, 16'h00FF, 16'hFF00), 1'b1, NONE});
    // Field extremes, then an endless repeat whose zero reload stops the timer.
    script_q.push_back('{op(K_ARM, 0, 0, 16'hFFFF, 16'hFFFF), 1'b0, NONE});
    script_q.push_back('{op(K_ARM, 0, 0, 1, 0), 1'b0, NONE});
    script_q.push_back('{op(K_TICK, 0, 0, 0, 0), 1'b0, NONE});
    script_q.push_back('{op(K_CHECK, 0, 0, 0, 0), 1'b0, NONE});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script_q[i]) offer(script_q[i].item, script_q[i].pinned, script_q[i].res);

    run_phase(1'b1, 16'd3);
    run_phase(1'b0, 16'd4);
    run_phase(1'b1, 16'd0);
    run_phase(1'b1, 16'hFFFF);
    run_phase(1'b0, 16'd1);
    run_phase(1'b1, 16'd2);

    // Drain every outstanding result.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pin_q.size() != 0 || awaited_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("vectored_interrupt_controller_timer_tb: done, clean");
    end else begin
      $display("vectored_interrupt_controller_timer_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== vectored_interrupt_controller_timer.f =====
src/vict_pkg.sv
src/vict_ram.sv
src/vict_ctrl.sv
src/vectored_interrupt_controller_timer.sv
sim/vectored_interrupt_controller_timer_tb.sv
